// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, disabled while in reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Assertion that a condition never holds.
`define ASSERT_NEVER(label, expr, msg) \
  `ASSERT_CLK(label, !(expr), msg)

`endif

// ===== rtl/core/itoa_pkg.sv =====
package itoa_pkg;

  // Widths of the value, radix, digit and character fields.
  localparam int VALUE_W   = 32;
  localparam int LEN_W     = $clog2(VALUE_W + 1);
  localparam int RADIX_W   = 6;
  localparam int DIGIT_W   = 6;
  localparam int CHAR_W    = 7;
  localparam int BUF_DEPTH = VALUE_W;
  localparam int ADDR_W    = $clog2(BUF_DEPTH);
  localparam int CNT_W     = $clog2(VALUE_W);

  // Radix limits and the radix that writes a sign.
  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] RADIX_DEC = RADIX_W'(10);

  // ASCII codes used in the text.
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX_DEC = DIGIT_W'(9);

  // Result of one division, as seen by the sequencer.
  typedef struct packed {
    logic                 done;
    logic [VALUE_W-1:0]   quotient;
    logic [DIGIT_W-1:0]   remainder;
  } div_res_t;

  // Map a digit value to its ASCII character.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = CHAR_W'(d);
    if (d > DIGIT_MAX_DEC) begin
      return CHAR_A + dx - CHAR_W'(RADIX_DEC);
    end
    return CHAR_ZERO + dx;
  endfunction

endpackage

// ===== rtl/core/int_to_ascii_radix_core.sv =====
// Integer to ASCII text converter.
// The input channel (value_valid, value_stall) takes one signed 32-bit value
// and a radix; a radix below 2 or above 36 is clamped into that range.
// The output channel (char_valid, char_stall) gives the text one character
// per item, most significant first, with last set on the final character and
// text_length giving the character count on every item of the text.
// Radix ten writes a minus sign before the magnitude of a negative value; any
// other radix writes the digits of the two's complement bit pattern.
// Each digit comes from one pass of a shared bit-serial divider: a start,
// the quotient bits, then the hand-off of the digit to the buffer.
// After all digits are stored, and a minus sign after them, each character
// takes a buffer read, then a show. One value is worked on at a time;
// value_stall is high from acceptance until the last character has been taken.
// A stalled character holds on the outputs until char_stall falls.
// Synchronous reset returns the block to idle with no character pending.
module int_to_ascii_radix_core import itoa_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                value_valid,
  output logic                value_stall,
  input  logic [VALUE_W-1:0]  value,
  input  logic [RADIX_W-1:0]  radix,
  output logic                char_valid,
  input  logic                char_stall,
  output logic [CHAR_W-1:0]   character,
  output logic                last,
  output logic [LEN_W-1:0]    text_length
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_WAIT,
    S_MINUS,
    S_READ,
    S_SHOW
  } state_t;

  state_t             state;
  logic [VALUE_W-1:0] num;
  logic [RADIX_W-1:0] radix_q;
  logic               minus;
  logic [LEN_W-1:0]   count;
  logic [ADDR_W-1:0]  idx;
  logic               div_start;
  div_res_t           div_res;

  logic [RADIX_W-1:0] radix_clamped;
  logic               negative;
  logic               buf_we;
  logic [CHAR_W-1:0]  buf_wdata;
  logic               buf_re;

  // Clamp the radix and decide whether a minus sign is written.
  always_comb begin
    radix_clamped = radix;
    if (radix < RADIX_MIN) begin
      radix_clamped = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      radix_clamped = RADIX_MAX;
    end
    negative = value[VALUE_W-1] && (radix_clamped == RADIX_DEC);
  end

  // Character buffer writes: digits least significant first, then the sign.
  always_comb begin
    buf_we    = ((state == S_WAIT) && div_res.done) || (state == S_MINUS);
    buf_wdata = (state == S_MINUS) ? CHAR_MINUS : digit_char(div_res.remainder);
    buf_re    = (state == S_READ);
  end

  itoa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (num),
    .divisor  (radix_q),
    .res      (div_res)
  );

  itoa_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (BUF_DEPTH)
  ) u_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (count[ADDR_W-1:0]),
    .wdata (buf_wdata),
    .re    (buf_re),
    .raddr (idx),
    .rdata (character)
  );

  // Sequencer: divide until the quotient is zero, then read the text back.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      div_start  <= 1'b0;
      char_valid <= 1'b0;
      last       <= 1'b0;
      count      <= '0;
      idx        <= '0;
      minus      <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (value_valid) begin
            num       <= negative ? (~value + VALUE_W'(1)) : value;
            radix_q   <= radix_clamped;
            minus     <= negative;
            count     <= '0;
            div_start <= 1'b1;
            state     <= S_START;
          end
        end
        S_START: begin
          div_start <= 1'b0;
          state     <= S_WAIT;
        end
        S_WAIT: begin
          if (div_res.done) begin
            count <= count + LEN_W'(1);
            num   <= div_res.quotient;
            if (div_res.quotient == '0) begin
              if (minus) begin
                state <= S_MINUS;
              end else begin
                idx   <= count[ADDR_W-1:0];
                state <= S_READ;
              end
            end else begin
              div_start <= 1'b1;
              state     <= S_START;
            end
          end
        end
        S_MINUS: begin
          count <= count + LEN_W'(1);
          idx   <= count[ADDR_W-1:0];
          state <= S_READ;
        end
        S_READ: begin
          char_valid <= 1'b1;
          last       <= (idx == '0);
          state      <= S_SHOW;
        end
        S_SHOW: begin
          if (!char_stall) begin
            char_valid <= 1'b0;
            if (last) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx - ADDR_W'(1);
              state <= S_READ;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign value_stall = (state != S_IDLE);
  assign text_length = count;

endmodule

// ===== rtl/core/itoa_ram.sv =====
module itoa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port; read data holds when idle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/itoa_div.sv =====
module itoa_div import itoa_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [VALUE_W-1:0]  dividend,
  input  logic [RADIX_W-1:0]  divisor,
  output div_res_t            res
);

  logic               busy;
  logic               done;
  logic [CNT_W-1:0]   cnt;
  logic [VALUE_W-1:0] quo;
  logic [DIGIT_W-1:0] rem;

  logic [DIGIT_W:0]   trial;
  logic [DIGIT_W:0]   diff;
  logic               ge;

  // One restoring step: shift in the next dividend bit and try to subtract.
  always_comb begin
    trial = {rem, quo[VALUE_W-1]};
    diff  = trial - {1'b0, divisor};
    ge    = (trial >= {1'b0, divisor});
  end

  // Divider sequencing, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo  <= dividend;
        rem  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        quo <= {quo[VALUE_W-2:0], ge};
        rem <= ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(VALUE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res.done      = done;
  assign res.quotient  = quo;
  assign res.remainder = rem;

endmodule

// ===== rtl/core/itoa_chk.sv =====
`include "assert_macros.svh"

module itoa_chk import itoa_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                value_valid,
  input logic                value_stall,
  input logic                char_valid,
  input logic                char_stall,
  input logic [CHAR_W-1:0]   character,
  input logic                last,
  input logic [LEN_W-1:0]    text_length
);

  // A newly accepted item never shows a character in the next cycle.
  `ASSERT_CLK(a_no_early_char, (value_valid && !value_stall) |=> !char_valid, "char too early")

  // No new item is taken while a character is on offer.
  `ASSERT_NEVER(a_busy_while_char, char_valid && !value_stall, "input ready during output")

  // After a character of a text is taken, the next one follows a buffer read.
  `ASSERT_CLK(a_next_char, (char_valid && !char_stall && !last) |=> !char_valid ##1 char_valid, "missing next char")

  // Text length stays within one to the value width.
  `ASSERT_CLK(a_len_range, char_valid |-> (text_length != '0 && text_length <= LEN_W'(VALUE_W)), "bad text length")

  // A stalled character holds.
  `ASSERT_CLK(a_hold, (char_valid && char_stall) |=> (char_valid && $stable(character)), "stalled char changed")

endmodule

bind int_to_ascii_radix_core itoa_chk u_itoa_chk (.*);
